>>> rtl/core/adam_pkg.sv
`timescale 1ns / 1ps
package adam_pkg;
    localparam int IDX_W = 12;
    localparam int ELEMENTS = 4096;
    localparam int DEPTH_W = 12;
    localparam logic [1:0] REG_LR = 2'd0;
    localparam logic [1:0] REG_B1 = 2'd1;
    localparam logic [1:0] REG_B2 = 2'd2;
    localparam logic [1:0] REG_EPS = 2'd3;
    localparam logic CMD_UPDATE = 1'b0;
    localparam logic CMD_STEP = 1'b1;
    localparam logic [23:0] LR_RESET = 24'd16777;
    localparam logic [15:0] B1_RESET = 16'd58982;
    localparam logic [15:0] B2_RESET = 16'd65470;
    localparam logic [15:0] EPS_RESET = 16'd1;
    localparam logic [23:0] RATE_RESET = 24'd5305;
endpackage

>>> rtl/core/adam_weight_update.sv
`timescale 1ns / 1ps
// Adam weight update. start is taken when busy is low and cfg_we is low; an
// update request keeps busy high through the moment read and write, eight
// multiplies on one shared 32x32 multiplier, a 32-step restoring square root
// (one result bit per cycle) and a 64-step restoring divider (one quotient bit
// per cycle). A step request updates the bias powers, recomputes the rate and
// gives no result. After reset a clearing pass zeroes all 4096 entries of the
// moment memories, during which busy is high. done strobes for the one cycle in
// which busy first drops, with out_index and new_weight; the receiver cannot stall it.
// Configuration writes are taken only while busy is low (a write while busy is
// dropped) and recompute the rate, during which busy is high.
module adam_weight_update (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [23:0]         cfg_data,
    input  logic                command,
    input  logic [11:0]         element_index,
    input  logic signed [31:0]  weight,
    input  logic signed [31:0]  gradient,
    output logic                done,
    output logic [11:0]         out_index,
    output logic signed [31:0]  new_weight
);
    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_RD, S_RDW, S_M1, S_M2, S_MSUM, S_G1, S_V1, S_V2, S_V3,
        S_V4, S_VSUM, S_SQ, S_DEN, S_NUM, S_DIV, S_OUT, S_P1, S_P2, S_R1, S_R2,
        S_RDIV, S_RDONE
    } state_t;

    localparam int ELEMENTS_C = adam_pkg::ELEMENTS;

    state_t state_reg;
    logic [23:0] lr_reg;
    logic [15:0] b1_reg, b2_reg, eps_reg, p1_reg, p2_reg;
    logic [23:0] rate_reg;
    logic [11:0] clr_reg, idx_reg;
    logic signed [31:0] w_reg, g_reg;
    logic signed [31:0] m_mem [ELEMENTS_C];
    logic [47:0] v_mem [ELEMENTS_C];
    logic signed [31:0] m_rd_reg;
    logic [47:0] v_rd_reg;
    logic mem_we;
    logic signed [31:0] m_wd;
    logic [47:0] v_wd;
    logic signed [63:0] acc_reg;
    logic [79:0] vacc_reg;
    logic signed [31:0] m_new_reg;
    logic [47:0] v_new_reg;
    // shared unsigned multiplier
    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_p, prod_reg;
    // square root
    logic [63:0] sq_x_reg, sq_res_reg;
    logic [5:0] cnt_reg;
    // divider
    logic [79:0] num_reg;
    logic [63:0] den_reg;
    logic [63:0] rem_reg;
    logic [79:0] quo_reg;
    logic [64:0] rem_sh;
    logic [31:0] mag_reg;
    logic neg_reg;
    logic done_reg;
    logic [11:0] oidx_reg;
    logic signed [31:0] nw_reg;
    logic [63:0] sq_trial;
    logic [63:0] sq_bit;
    logic signed [81:0] nw_sum;

    assign mul_p = mul_a * mul_b;
    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;
    assign out_index = oidx_reg;
    assign new_weight = nw_reg;
    assign sq_bit = 64'd1 << {cnt_reg[4:0], 1'b0};
    assign sq_trial = sq_res_reg + sq_bit;
    assign rem_sh = {rem_reg, num_reg[79]};
    assign nw_sum = neg_reg ? ($signed({{50{w_reg[31]}}, w_reg}) + $signed({2'b0, quo_reg}))
                            : ($signed({{50{w_reg[31]}}, w_reg}) - $signed({2'b0, quo_reg}));

    always_comb
    begin
        mul_a = 32'd0;
        mul_b = 32'd0;
        case (state_reg)
            S_M1: begin mul_a = {16'd0, b1_reg};
                mul_b = m_rd_reg[31] ? -m_rd_reg : m_rd_reg; end
            S_M2: begin mul_a = {15'd0, 17'h10000 - {1'b0, b1_reg}};
                mul_b = g_reg[31] ? -g_reg : g_reg; end
            S_G1: begin mul_a = g_reg[31] ? -g_reg : g_reg;
                mul_b = g_reg[31] ? -g_reg : g_reg; end
            S_V1: begin mul_a = {16'd0, b2_reg}; mul_b = v_rd_reg[31:0]; end
            S_V2: begin mul_a = {16'd0, b2_reg}; mul_b = {16'd0, v_rd_reg[47:32]}; end
            // squared gradient is taken in a low and a high half
            S_V3: begin mul_a = {15'd0, 17'h10000 - {1'b0, b2_reg}};
                mul_b = prod_reg[47:16]; end
            S_V4: begin mul_a = {15'd0, 17'h10000 - {1'b0, b2_reg}};
                mul_b = {16'd0, prod_reg[63:48]}; end
            S_NUM: begin mul_a = {8'd0, rate_reg}; mul_b = mag_reg; end
            S_P1: begin mul_a = {16'd0, p1_reg}; mul_b = {16'd0, b1_reg}; end
            S_P2: begin mul_a = {16'd0, p2_reg}; mul_b = {16'd0, b2_reg}; end
            S_R2: begin mul_a = {8'd0, lr_reg}; mul_b = sq_res_reg[31:0]; end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            m_mem[mem_we ? (state_reg == S_CLEAR ? clr_reg : idx_reg) : 12'd0] <= m_wd;
            v_mem[state_reg == S_CLEAR ? clr_reg : idx_reg] <= v_wd;
        end
        m_rd_reg <= m_mem[idx_reg];
        v_rd_reg <= v_mem[idx_reg];
    end

    always_comb
    begin
        mem_we = (state_reg == S_CLEAR) || (state_reg == S_SQ && cnt_reg == 6'd32);
        m_wd = (state_reg == S_CLEAR) ? 32'sd0 : m_new_reg;
        v_wd = (state_reg == S_CLEAR) ? 48'd0 : v_new_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            lr_reg <= adam_pkg::LR_RESET;
            b1_reg <= adam_pkg::B1_RESET;
            b2_reg <= adam_pkg::B2_RESET;
            eps_reg <= adam_pkg::EPS_RESET;
            p1_reg <= adam_pkg::B1_RESET;
            p2_reg <= adam_pkg::B2_RESET;
            rate_reg <= adam_pkg::RATE_RESET;
            clr_reg <= 12'd0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + 12'd1;
                    if (clr_reg == 12'hFFF)
                        state_reg <= S_IDLE;
                end
                S_IDLE:
                begin
                    if (cfg_we)
                    begin
                        case (cfg_index)
                            adam_pkg::REG_LR: lr_reg <= cfg_data;
                            adam_pkg::REG_B1: begin b1_reg <= cfg_data[15:0];
                                p1_reg <= cfg_data[15:0]; p2_reg <= b2_reg; end
                            adam_pkg::REG_B2: begin b2_reg <= cfg_data[15:0];
                                p2_reg <= cfg_data[15:0]; p1_reg <= b1_reg; end
                            default: eps_reg <= cfg_data[15:0];
                        endcase
                        if (cfg_index == adam_pkg::REG_LR || cfg_index == adam_pkg::REG_EPS)
                        begin
                            p1_reg <= b1_reg;
                            p2_reg <= b2_reg;
                        end
                        state_reg <= S_R1;
                        cnt_reg <= 6'd32;
                    end
                    else if (start)
                    begin
                        idx_reg <= element_index;
                        w_reg <= weight;
                        g_reg <= gradient;
                        state_reg <= (command == adam_pkg::CMD_STEP) ? S_P1 : S_RD;
                    end
                end
                S_RD: state_reg <= S_RDW;
                S_RDW: state_reg <= S_M1;
                S_M1:
                begin
                    acc_reg <= m_rd_reg[31] ? -$signed({1'b0, mul_p[62:0]})
                                            : $signed({1'b0, mul_p[62:0]});
                    state_reg <= S_M2;
                end
                S_M2:
                begin
                    acc_reg <= acc_reg + (g_reg[31] ? -$signed({1'b0, mul_p[62:0]})
                                                    : $signed({1'b0, mul_p[62:0]}));
                    state_reg <= S_MSUM;
                end
                S_MSUM:
                begin
                    m_new_reg <= acc_reg[47:16];
                    state_reg <= S_G1;
                end
                S_G1: begin prod_reg <= mul_p; state_reg <= S_V1; end
                S_V1: begin vacc_reg <= {16'd0, mul_p}; state_reg <= S_V2; end
                S_V2: begin vacc_reg <= vacc_reg + {mul_p[47:0], 32'd0}; state_reg <= S_V3; end
                S_V3:
                begin
                    vacc_reg <= vacc_reg + {16'd0, mul_p};
                    state_reg <= S_V4;
                end
                S_V4:
                begin
                    vacc_reg <= vacc_reg + {mul_p[47:0], 32'd0};
                    state_reg <= S_VSUM;
                end
                S_VSUM:
                begin
                    v_new_reg <= vacc_reg[63:16];
                    sq_x_reg <= {vacc_reg[63:16], 16'd0};
                    sq_res_reg <= 64'd0;
                    cnt_reg <= 6'd31;
                    state_reg <= S_SQ;
                end
                S_SQ:
                begin
                    if (cnt_reg == 6'd32)
                        state_reg <= S_DEN;
                    else
                    begin
                        if (sq_x_reg >= sq_trial)
                        begin
                            sq_x_reg <= sq_x_reg - sq_trial;
                            sq_res_reg <= (sq_res_reg >> 1) + sq_bit;
                        end
                        else
                            sq_res_reg <= sq_res_reg >> 1;
                        cnt_reg <= (cnt_reg == 6'd0) ? 6'd32 : cnt_reg - 6'd1;
                    end
                end
                S_DEN:
                begin
                    den_reg <= ((sq_res_reg + {48'd0, eps_reg}) == 64'd0) ? 64'd256
                               : {(sq_res_reg[55:0] + {40'd0, eps_reg}), 8'd0};
                    neg_reg <= m_new_reg[31];
                    mag_reg <= m_new_reg[31] ? -m_new_reg : m_new_reg;
                    state_reg <= S_NUM;
                end
                S_NUM:
                begin
                    // dividend sits in the top 64 bits, which the divider walks
                    num_reg <= {mul_p, 16'd0};
                    rem_reg <= 64'd0;
                    quo_reg <= 80'd0;
                    cnt_reg <= 6'd0;
                    state_reg <= S_DIV;
                end
                S_DIV, S_RDIV:
                begin
                    num_reg <= num_reg << 1;
                    if (rem_sh >= {1'b0, den_reg})
                    begin
                        rem_reg <= rem_sh[63:0] - den_reg;
                        quo_reg <= {quo_reg[78:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= rem_sh[63:0];
                        quo_reg <= {quo_reg[78:0], 1'b0};
                    end
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'd63)
                        state_reg <= (state_reg == S_DIV) ? S_OUT : S_RDONE;
                end
                S_OUT:
                begin
                    done_reg <= 1'b1;
                    oidx_reg <= idx_reg;
                    if (nw_sum > 82'sd2147483647) nw_reg <= 32'sh7FFFFFFF;
                    else if (nw_sum < -82'sd2147483648) nw_reg <= 32'sh80000000;
                    else nw_reg <= nw_sum[31:0];
                    state_reg <= S_IDLE;
                end
                S_P1: begin p1_reg <= mul_p[31:16]; state_reg <= S_P2; end
                S_P2: begin p2_reg <= mul_p[31:16]; cnt_reg <= 6'd32; state_reg <= S_R1; end
                S_R1:
                begin
                    if (cnt_reg == 6'd32)
                    begin
                        sq_x_reg <= {31'd0, 17'h10000 - {1'b0, p2_reg}, 16'd0};
                        sq_res_reg <= 64'd0;
                        cnt_reg <= 6'd31;
                    end
                    else
                    begin
                        if (sq_x_reg >= sq_trial)
                        begin
                            sq_x_reg <= sq_x_reg - sq_trial;
                            sq_res_reg <= (sq_res_reg >> 1) + sq_bit;
                        end
                        else
                            sq_res_reg <= sq_res_reg >> 1;
                        if (cnt_reg == 6'd0) state_reg <= S_R2;
                        cnt_reg <= cnt_reg - 6'd1;
                    end
                end
                S_R2:
                begin
                    num_reg <= {mul_p, 16'd0};
                    den_reg <= {47'd0, 17'h10000 - {1'b0, p1_reg}};
                    rem_reg <= 64'd0;
                    quo_reg <= 80'd0;
                    cnt_reg <= 6'd0;
                    state_reg <= S_RDIV;
                end
                S_RDONE:
                begin
                    rate_reg <= (quo_reg > 80'hFFFFFF) ? 24'hFFFFFF : quo_reg[23:0];
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done) else $error("done held");
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy) else $error("done while busy");
endmodule

>>> verif/tb_adam_weight_update.sv
`timescale 1ns / 1ps
module tb_adam_weight_update;

    typedef struct {
        logic [11:0] index;
        logic [31:0] weight;
    } weight_result_t;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic               cfg_we;
    logic [1:0]         cfg_index;
    logic [23:0]        cfg_data;
    logic               command;
    logic [11:0]        element_index;
    logic signed [31:0] weight;
    logic signed [31:0] gradient;
    logic               done;
    logic [11:0]        out_index;
    logic signed [31:0] new_weight;

    adam_weight_update i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .command       (command),
        .element_index (element_index),
        .weight        (weight),
        .gradient      (gradient),
        .done          (done),
        .out_index     (out_index),
        .new_weight    (new_weight)
    );

    // shadow copy of the optimiser state
    longint      first_mom [0:adam_pkg::ELEMENTS-1];
    logic [63:0] second_mom [0:adam_pkg::ELEMENTS-1];
    logic [63:0] lr_reg;
    logic [63:0] b1_reg;
    logic [63:0] b2_reg;
    logic [63:0] eps_reg;
    logic [63:0] b1_pow;
    logic [63:0] b2_pow;
    logic [63:0] rate;

    weight_result_t pending_weights[$];
    int  mismatches;
    int  update_count;
    int  step_count;
    int  write_count;
    int  result_count;
    bit  no_idle;

    initial clk = 1'b0;
    always #2 clk = ~clk;

    function automatic logic [63:0] int_sqrt(input logic [63:0] x);
        logic [63:0] res;
        logic [63:0] bit_pos;
        res = 64'd0;
        bit_pos = 64'h4000_0000_0000_0000;
        while (bit_pos > x)
            bit_pos = bit_pos >> 2;
        while (bit_pos != 0)
        begin
            if (x >= res + bit_pos)
            begin
                x = x - (res + bit_pos);
                res = (res >> 1) + bit_pos;
            end
            else
                res = res >> 1;
            bit_pos = bit_pos >> 2;
        end
        return res;
    endfunction

    function automatic void refresh_rate();
        logic [63:0] d1;
        logic [63:0] d2;
        logic [63:0] root;
        logic [63:0] q;
        d2 = 64'd65536 - b2_pow;
        d1 = 64'd65536 - b1_pow;
        root = int_sqrt(d2 << 16);
        q = (lr_reg * root) / d1;
        rate = (q > 64'hFF_FFFF) ? 64'hFF_FFFF : q;
    endfunction

    function automatic logic [31:0] adam_weight(input logic [11:0] idx,
                                                input logic signed [31:0] w,
                                                input logic signed [31:0] g);
        longint      m;
        longint      gl;
        longint      nw;
        logic [63:0] gabs;
        logic [63:0] gsq;
        logic [63:0] v;
        logic [63:0] den;
        logic [63:0] mag;
        logic [63:0] q;
        gl = longint'(g);
        m = (longint'(b1_reg) * first_mom[idx] + longint'(64'd65536 - b1_reg) * gl) >>> 16;
        first_mom[idx] = m;
        gabs = (gl < 0) ? 64'(-gl) : 64'(gl);
        gsq = (gabs * gabs) >> 16;
        v = (b2_reg * second_mom[idx] + (64'd65536 - b2_reg) * gsq) >> 16;
        v = v & 64'hFFFF_FFFF_FFFF;
        second_mom[idx] = v;
        den = int_sqrt(v << 16) + eps_reg;
        if (den == 0)
            den = 64'd1;
        mag = (m < 0) ? 64'(-m) : 64'(m);
        q = (rate * mag) / (den * 64'd256);
        nw = (m < 0) ? longint'(w) + longint'(q) : longint'(w) - longint'(q);
        if (nw > 64'sd2147483647)
            nw = 64'sd2147483647;
        if (nw < -64'sd2147483648)
            nw = -64'sd2147483648;
        return nw[31:0];
    endfunction

    // every result is compared with the oldest outstanding request
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            result_count++;
            if (pending_weights.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: index %0d weight %0d", out_index, new_weight);
            end
            else
            begin
                weight_result_t exp_r;
                exp_r = pending_weights.pop_front();
                if (out_index !== exp_r.index || new_weight !== exp_r.weight)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: index exp %0d got %0d, weight exp %0d got %0d",
                                 exp_r.index, out_index, $signed(exp_r.weight), new_weight);
                end
            end
        end
    end

    task automatic send_request(input logic cmd, input logic [11:0] idx,
                                input logic signed [31:0] w, input logic signed [31:0] g);
        int gap;
        weight_result_t r;
        gap = (no_idle || $urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 17);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        command <= cmd;
        element_index <= idx;
        weight <= w;
        gradient <= g;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        if (cmd == adam_pkg::CMD_STEP)
        begin
            step_count++;
            b1_pow = (b1_pow * b1_reg) >> 16;
            b2_pow = (b2_pow * b2_reg) >> 16;
            refresh_rate();
        end
        else
        begin
            update_count++;
            r.index = idx;
            r.weight = adam_weight(idx, w, g);
            pending_weights.push_back(r);
        end
    endtask

    // lets the block settle so that a register write finds it idle
    task automatic drain_block();
        @(posedge clk);
        start <= 1'b0;
        while (pending_weights.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic write_register(input logic [1:0] index, input logic [23:0] data);
        drain_block();
        cfg_we <= 1'b1;
        cfg_index <= index;
        cfg_data <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (index)
            adam_pkg::REG_LR:  lr_reg = 64'(data);
            adam_pkg::REG_B1:  b1_reg = 64'(data[15:0]);
            adam_pkg::REG_B2:  b2_reg = 64'(data[15:0]);
            default:           eps_reg = 64'(data[15:0]);
        endcase
        b1_pow = b1_reg;
        b2_pow = b2_reg;
        refresh_rate();
        write_count++;
        repeat (2) @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic test_reset_defaults();
        send_request(adam_pkg::CMD_UPDATE, 12'd0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
        send_request(adam_pkg::CMD_UPDATE, 12'd0, 32'sh8000_0000, 32'sh8000_0000);
        send_request(adam_pkg::CMD_UPDATE, 12'd4095, 32'sd0, 32'sh0001_0000);
        send_request(adam_pkg::CMD_UPDATE, 12'd4095, 32'sh0002_0000, -32'sh0001_0000);
        send_request(adam_pkg::CMD_STEP, 12'hFFF, 32'sh1234_5678, 32'sh8765_4321);
        send_request(adam_pkg::CMD_UPDATE, 12'd1, -32'sd1, 32'sd0);
        send_request(adam_pkg::CMD_STEP, 12'd0, 32'sd0, 32'sd0);
        send_request(adam_pkg::CMD_UPDATE, 12'd0, 32'sd65536, 32'sd65536);
    endtask

    task automatic test_zero_denominator();
        write_register(adam_pkg::REG_EPS, 24'd0);
        // fresh elements with tiny gradients keep the second moment at zero
        send_request(adam_pkg::CMD_UPDATE, 12'd4000, 32'sd12345, 32'sd0);
        send_request(adam_pkg::CMD_UPDATE, 12'd4001, 32'sd12345, 32'sd200);
        send_request(adam_pkg::CMD_UPDATE, 12'd4002, -32'sd5, -32'sd255);
    endtask

    task automatic test_register_extremes();
        write_register(adam_pkg::REG_LR, 24'hFF_FFFF);
        write_register(adam_pkg::REG_EPS, 24'h00_FFFF);
        send_request(adam_pkg::CMD_UPDATE, 12'd7, 32'sh7FFF_0000, -32'sh7000_0000);
        send_request(adam_pkg::CMD_UPDATE, 12'd8, 32'sh8000_0100, 32'sh7000_0000);
        write_register(adam_pkg::REG_B1, 24'd0);
        write_register(adam_pkg::REG_B2, 24'd0);
        write_register(adam_pkg::REG_EPS, 24'd1);
        send_request(adam_pkg::CMD_UPDATE, 12'd9, 32'sh7FFF_FFF0, -32'sh4000_0000);
        send_request(adam_pkg::CMD_STEP, 12'd0, 32'sd0, 32'sd0);
        send_request(adam_pkg::CMD_UPDATE, 12'd9, 32'sh8000_0010, 32'sh4000_0000);
        write_register(adam_pkg::REG_B1, 24'h00_FFFF);
        write_register(adam_pkg::REG_B2, 24'h00_FFFF);
        send_request(adam_pkg::CMD_UPDATE, 12'd10, 32'sd0, 32'sh7FFF_FFFF);
        send_request(adam_pkg::CMD_STEP, 12'd0, 32'sd0, 32'sd0);
        send_request(adam_pkg::CMD_UPDATE, 12'd10, 32'sd0, 32'sh8000_0000);
        write_register(adam_pkg::REG_LR, 24'd0);
        send_request(adam_pkg::CMD_UPDATE, 12'd11, 32'sd99, 32'sh0100_0000);
    endtask

    task automatic test_random_training();
        int phase;
        int n;
        logic [11:0] idx;
        logic [31:0] g;
        for (phase = 0; phase < 5; phase++)
        begin
            write_register(adam_pkg::REG_LR, (phase == 1) ? 24'hFF_FFFF : 24'($urandom));
            write_register(adam_pkg::REG_B1,
                           (phase == 2) ? 24'd0 : 24'($urandom_range(0, 65535)));
            write_register(adam_pkg::REG_B2,
                           (phase == 2) ? 24'h00_FFFF : 24'($urandom_range(0, 65535)));
            write_register(adam_pkg::REG_EPS, 24'($urandom_range(0, 65535)));
            no_idle = (phase == 4);
            for (n = 0; n < 200; n++)
            begin
                if ($urandom_range(0, 9) == 0)
                    send_request(adam_pkg::CMD_STEP, 12'($urandom), 32'($urandom),
                                 32'($urandom));
                else
                begin
                    // a small pool of elements lets the moments build up
                    idx = ($urandom_range(0, 3) == 0) ? 12'($urandom)
                                                       : 12'($urandom_range(0, 15));
                    case ($urandom_range(0, 3))
                        0:       g = 32'($urandom);
                        1:       g = 32'($signed(16'($urandom)));
                        2:       g = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
                        default: g = 32'($signed(24'($urandom)));
                    endcase
                    send_request(adam_pkg::CMD_UPDATE, idx, 32'($urandom), g);
                end
            end
        end
    endtask

    initial
    begin
        int i;
        rst_n = 1'b0;
        start = 1'b0;
        cfg_we = 1'b0;
        cfg_index = adam_pkg::REG_LR;
        cfg_data = 24'd0;
        command = adam_pkg::CMD_UPDATE;
        element_index = 12'd0;
        weight = 32'sd0;
        gradient = 32'sd0;
        mismatches = 0;
        update_count = 0;
        step_count = 0;
        write_count = 0;
        result_count = 0;
        no_idle = 1'b0;
        for (i = 0; i < adam_pkg::ELEMENTS; i++)
        begin
            first_mom[i] = 0;
            second_mom[i] = 64'd0;
        end
        lr_reg = 64'(adam_pkg::LR_RESET);
        b1_reg = 64'(adam_pkg::B1_RESET);
        b2_reg = 64'(adam_pkg::B2_RESET);
        eps_reg = 64'(adam_pkg::EPS_RESET);
        b1_pow = 64'(adam_pkg::B1_RESET);
        b2_pow = 64'(adam_pkg::B2_RESET);
        rate = 64'(adam_pkg::RATE_RESET);
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        // wait out the clearing pass
        @(posedge clk);
        while (busy)
            @(posedge clk);

        test_reset_defaults();
        test_zero_denominator();
        test_register_extremes();
        test_random_training();
        drain_block();

        $display("covered %0d updates, %0d time steps and %0d register writes; %0d results checked",
                 update_count, step_count, write_count, result_count);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
        begin
            $display("%0d mismatches in total", mismatches);
            $display("TEST FAILED");
        end
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("timeout");
        $display("TEST FAILED");
        $finish;
    end
endmodule
